### hw/rtl/button_debounce_hold_events_macros.svh
// Assertion macros for the button debouncer with hold events.
// Used by the top level; expects clk and arst_n in scope.
`ifndef BUTTON_DEBOUNCE_HOLD_EVENTS_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_EVENTS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDHE_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("button debouncer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BDHE_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("button debouncer: next-cycle check failed");

`endif

### hw/rtl/bdhe_pkg.sv
// Shared types and constants for the button debouncer with hold events.
// No dependencies.
package bdhe_pkg;

	localparam int DURATION_WIDTH     = 32;
	localparam int OUT_DURATION_WIDTH = 32;
	localparam int QUIET_WIDTH        = 16;
	localparam int HOLD_WIDTH         = 32;
	localparam int CFG_DATA_WIDTH     = 32;
	localparam int CFG_INDEX_WIDTH    = 2;
	localparam int THR_WIDTH = (DURATION_WIDTH > HOLD_WIDTH) ? DURATION_WIDTH : HOLD_WIDTH;

	typedef logic [DURATION_WIDTH-1:0]     duration_t;
	typedef logic [OUT_DURATION_WIDTH-1:0] out_duration_t;
	typedef logic [QUIET_WIDTH-1:0]        quiet_t;
	typedef logic [HOLD_WIDTH-1:0]         hold_t;
	typedef logic [THR_WIDTH-1:0]          thr_t;
	typedef logic [CFG_DATA_WIDTH-1:0]     cfg_data_t;
	typedef logic [CFG_INDEX_WIDTH-1:0]    cfg_index_t;

	localparam cfg_index_t CFG_DEBOUNCE_TICKS   = 2'd0;
	localparam cfg_index_t CFG_FIRST_HOLD_TICKS = 2'd1;
	localparam cfg_index_t CFG_NEXT_HOLD_TICKS  = 2'd2;

	localparam quiet_t RST_DEBOUNCE_TICKS   = 16'd20;
	localparam hold_t  RST_FIRST_HOLD_TICKS = 32'd1000;
	localparam hold_t  RST_NEXT_HOLD_TICKS  = 32'd300;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_HOLD    = 2'd3
	} event_t;

	// Debounced level before and after the current sample (1 means pressed).
	typedef struct packed {
		logic was_pressed;
		logic now_pressed;
	} level_t;

	typedef struct packed {
		event_t        event_code;
		logic          click;
		logic          is_pressed;
		out_duration_t pressed_duration;
	} result_t;

endpackage

### hw/rtl/bdhe_in_if.sv
// Input channel of the button debouncer: one raw pin sample per transaction.
// Depends on nothing.
interface bdhe_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

### hw/rtl/bdhe_out_if.sv
// Output channel of the button debouncer: one event result per transaction.
// Depends on bdhe_pkg.
interface bdhe_out_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              event_code;
	logic                    click;
	logic                    is_pressed;
	bdhe_pkg::out_duration_t pressed_duration;

	modport source (output valid, output event_code, output click, output is_pressed,
		output pressed_duration, input ready);
	modport sink (input valid, input event_code, input click, input is_pressed,
		input pressed_duration, output ready);
endinterface

### hw/rtl/bdhe_debounce.sv
// Debounce stage: raw sample tracking, quiet-time counter and debounced level.
// Depends on bdhe_pkg.
module bdhe_debounce (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             pin_level,
	input  bdhe_pkg::quiet_t debounce_ticks,
	output bdhe_pkg::level_t level
);

	logic             raw_q;
	logic             stable_q;
	bdhe_pkg::quiet_t quiet_q;
	bdhe_pkg::quiet_t quiet_inc;
	logic             change;
	logic             stable_next;

	assign change    = (pin_level != raw_q);
	assign quiet_inc = (quiet_q == '1) ? quiet_q : quiet_q + 1'b1;

	always_comb begin
		stable_next = stable_q;
		if (!change && (pin_level != stable_q) && (quiet_inc >= debounce_ticks)) begin
			stable_next = pin_level;
		end
	end

	// Levels are active low on the pin; the struct carries "pressed" as 1.
	assign level.was_pressed = !stable_q;
	assign level.now_pressed = !stable_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b1;
			stable_q <= 1'b1;
			quiet_q  <= '0;
		end else if (advance) begin
			raw_q    <= pin_level;
			stable_q <= stable_next;
			quiet_q  <= change ? '0 : quiet_inc;
		end
	end

endmodule

### hw/rtl/bdhe_events.sv
// Event stage: press duration counter, press/release/hold detection and click.
// Depends on bdhe_pkg.
module bdhe_events (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  bdhe_pkg::level_t  level,
	input  bdhe_pkg::hold_t   first_hold_ticks,
	input  bdhe_pkg::hold_t   next_hold_ticks,
	output bdhe_pkg::result_t result
);

	bdhe_pkg::duration_t press_q;
	bdhe_pkg::duration_t last_q;
	logic                first_done_q;
	bdhe_pkg::event_t    prev_q;

	bdhe_pkg::duration_t cur;
	bdhe_pkg::duration_t diff;
	bdhe_pkg::thr_t      thr;
	bdhe_pkg::event_t    ev;

	always_comb begin
		if (!level.now_pressed) begin
			cur = '0;
		end else if (!level.was_pressed) begin
			cur = bdhe_pkg::duration_t'(1);
		end else if (press_q != '1) begin
			cur = press_q + 1'b1;
		end else begin
			cur = press_q;
		end
	end

	assign thr  = bdhe_pkg::thr_t'(first_done_q ? next_hold_ticks : first_hold_ticks);
	assign diff = cur - last_q;

	always_comb begin
		ev = bdhe_pkg::EV_NONE;
		if (cur != last_q) begin
			if (cur == '0) begin
				ev = bdhe_pkg::EV_RELEASE;
			end else if (last_q == '0) begin
				ev = bdhe_pkg::EV_PRESS;
			end else if (bdhe_pkg::thr_t'(diff) > thr) begin
				ev = bdhe_pkg::EV_HOLD;
			end
		end
	end

	assign result.event_code = ev;
	assign result.click      = (ev == bdhe_pkg::EV_RELEASE) && (prev_q == bdhe_pkg::EV_PRESS);
	assign result.is_pressed = level.now_pressed;
	assign result.pressed_duration = ((cur >> bdhe_pkg::OUT_DURATION_WIDTH) != '0) ? '1 :
		bdhe_pkg::out_duration_t'(cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q      <= '0;
			last_q       <= '0;
			first_done_q <= 1'b0;
			prev_q       <= bdhe_pkg::EV_NONE;
		end else if (advance) begin
			press_q <= cur;
			if (ev != bdhe_pkg::EV_NONE) begin
				last_q       <= cur;
				first_done_q <= (ev == bdhe_pkg::EV_HOLD);
				prev_q       <= ev;
			end
		end
	end

endmodule

### hw/rtl/button_debounce_hold_events.sv
// Top level of the button debouncer with press, release, hold-repeat and click events.
// Depends on bdhe_pkg, bdhe_in_if, bdhe_out_if, bdhe_debounce, bdhe_events and the macros.
// The result of a sample is registered and valid in the cycle after its transaction.
// Throughput: one sample per cycle without back-pressure; one update per transaction.
// Reset (arst_n low, asynchronous): button released, counters cleared, registers at
// their defaults (debounce 20, first hold 1000, next hold 300), no result pending.
`include "button_debounce_hold_events_macros.svh"

module button_debounce_hold_events (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  bdhe_pkg::cfg_index_t cfg_index,
	input  bdhe_pkg::cfg_data_t  cfg_wdata,
	bdhe_in_if.sink              sample,
	bdhe_out_if.source           result
);

	// Configuration registers. The user must write them only while the block is idle;
	// the block does not enforce this. Writes are applied directly with no shadowing.
	bdhe_pkg::quiet_t debounce_ticks_q;
	bdhe_pkg::hold_t  first_hold_ticks_q;
	bdhe_pkg::hold_t  next_hold_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= bdhe_pkg::RST_DEBOUNCE_TICKS;
			first_hold_ticks_q <= bdhe_pkg::RST_FIRST_HOLD_TICKS;
			next_hold_ticks_q  <= bdhe_pkg::RST_NEXT_HOLD_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdhe_pkg::CFG_DEBOUNCE_TICKS: begin
					debounce_ticks_q <= cfg_wdata[bdhe_pkg::QUIET_WIDTH-1:0];
				end
				bdhe_pkg::CFG_FIRST_HOLD_TICKS: begin
					first_hold_ticks_q <= cfg_wdata[bdhe_pkg::HOLD_WIDTH-1:0];
				end
				bdhe_pkg::CFG_NEXT_HOLD_TICKS: begin
					next_hold_ticks_q <= cfg_wdata[bdhe_pkg::HOLD_WIDTH-1:0];
				end
				default: begin
					// Indices beyond the register list are ignored.
				end
			endcase
		end
	end

	// Handshake. The output register behaves as a pipeline stage: a new sample
	// is taken whenever the register is empty or its contents leave in the same
	// cycle, so the block streams one transaction per cycle under no back-pressure.
	logic              out_valid_q;
	bdhe_pkg::result_t out_data_q;
	logic              accept;

	assign sample.ready = !out_valid_q || result.ready;
	assign accept       = sample.valid && sample.ready;

	// Processing. Both stages compute their next state combinationally from the
	// incoming sample and commit it only when the sample's transaction completes.
	bdhe_pkg::level_t  level;
	bdhe_pkg::result_t next_result;

	bdhe_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (accept),
		.pin_level      (sample.pin_level),
		.debounce_ticks (debounce_ticks_q),
		.level          (level)
	);

	bdhe_events u_events (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (accept),
		.level            (level),
		.first_hold_ticks (first_hold_ticks_q),
		.next_hold_ticks  (next_hold_ticks_q),
		.result           (next_result)
	);

	// Result register. The payload needs no reset; only the valid flag does.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= next_result;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.event_code       = out_data_q.event_code;
	assign result.click            = out_data_q.click;
	assign result.is_pressed       = out_data_q.is_pressed;
	assign result.pressed_duration = out_data_q.pressed_duration;

	// Terms used by the checks below.
	logic out_is_press;
	logic out_has_duration;

	assign out_is_press     = out_valid_q && (out_data_q.event_code == bdhe_pkg::EV_PRESS);
	assign out_has_duration = (out_data_q.pressed_duration != '0);

	// A pressed button always reports a non-zero duration, a released one zero.
	`BDHE_ASSERT_NOW(a_pressed_duration, out_valid_q, out_data_q.is_pressed == out_has_duration)
	// A press event is reported on the first pressed tick.
	`BDHE_ASSERT_NOW(a_press_first_tick, out_is_press, out_data_q.pressed_duration == 32'd1)
	// A click only accompanies a release.
	`BDHE_ASSERT_NOW(a_click_on_release, out_valid_q && out_data_q.click, out_data_q.event_code == bdhe_pkg::EV_RELEASE)
	// Every accepted sample produces a result in the following cycle.
	`BDHE_ASSERT_NEXT(a_result_follows, accept, out_valid_q)

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_hold_events: directed and shaped random traffic.
// Depends on bdhe_pkg, bdhe_in_if, bdhe_out_if and the block's RTL.

module tb;
	import bdhe_pkg::*;

	// Index past the end of the register list; a write to it must change nothing.
	localparam cfg_index_t CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_OFF_CYCLES = 160;
	localparam int REPORT_LIMIT = 10;

	// The scoreboard keeps its own copy of the debouncer state and registers. Each accepted
	// sample is run through that copy at once and the result it must cause is queued; each
	// accepted result is compared with the oldest queued one.
	class event_scoreboard;
		quiet_t deb_ticks;
		hold_t first_hold;
		hold_t next_hold;

		logic raw_prev;
		quiet_t quiet_cnt;
		logic stable_lvl;
		duration_t press_cnt;
		duration_t last_event_cnt;
		logic hold_seen;
		event_t last_event;

		result_t expected_events[$];
		int mismatches;

		function new();
			deb_ticks = RST_DEBOUNCE_TICKS;
			first_hold = RST_FIRST_HOLD_TICKS;
			next_hold = RST_NEXT_HOLD_TICKS;
			raw_prev = 1'b1;
			quiet_cnt = '0;
			stable_lvl = 1'b1;
			press_cnt = '0;
			last_event_cnt = '0;
			hold_seen = 1'b0;
			last_event = EV_NONE;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_index_t idx, cfg_data_t data);
			case (idx)
				CFG_DEBOUNCE_TICKS: deb_ticks = data[QUIET_WIDTH-1:0];
				CFG_FIRST_HOLD_TICKS: first_hold = data[HOLD_WIDTH-1:0];
				CFG_NEXT_HOLD_TICKS: next_hold = data[HOLD_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic pin);
			hold_t thr;
			logic was_pressed;
			event_t ev;
			logic is_click;
			duration_t cur;
			result_t exp_res;

			// The threshold is picked before this tick can set or clear the hold flag.
			thr = hold_seen ? next_hold : first_hold;
			was_pressed = (stable_lvl == 1'b0);
			ev = EV_NONE;
			is_click = 1'b0;

			if (pin != raw_prev) begin
				raw_prev = pin;
				quiet_cnt = '0;
			end else begin
				if (quiet_cnt != '1)
					quiet_cnt = quiet_cnt + 1'b1;
				if (pin != stable_lvl && quiet_cnt >= deb_ticks)
					stable_lvl = pin;
			end

			if (stable_lvl) begin
				press_cnt = '0;
			end else if (!was_pressed) begin
				press_cnt = duration_t'(1);
			end else if (press_cnt != '1) begin
				press_cnt = press_cnt + 1'b1;
			end

			cur = press_cnt;
			if (cur != last_event_cnt) begin
				if (cur == '0) begin
					ev = EV_RELEASE;
					last_event_cnt = cur;
					hold_seen = 1'b0;
				end else if (last_event_cnt == '0) begin
					ev = EV_PRESS;
					last_event_cnt = cur;
					hold_seen = 1'b0;
				end else if ((64'(cur) - 64'(last_event_cnt)) > 64'(thr)) begin
					ev = EV_HOLD;
					last_event_cnt = cur;
					hold_seen = 1'b1;
				end
			end

			if (ev != EV_NONE) begin
				if (ev == EV_RELEASE && last_event == EV_PRESS)
					is_click = 1'b1;
				last_event = ev;
			end

			exp_res.event_code = ev;
			exp_res.click = is_click;
			exp_res.is_pressed = ~stable_lvl;
			exp_res.pressed_duration = (64'(cur) > 64'hFFFF_FFFF) ? '1 : out_duration_t'(cur);
			expected_events.push_back(exp_res);
		endfunction

		function void check_result(result_t got);
			result_t want;

			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result with no sample behind it: event %0d click %0b",
						got.event_code, got.click, " pressed %0b dur %0d",
						got.is_pressed, got.pressed_duration);
				return;
			end
			want = expected_events.pop_front();
			if (got.event_code !== want.event_code || got.click !== want.click ||
					got.is_pressed !== want.is_pressed ||
					got.pressed_duration !== want.pressed_duration) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("mismatch: expected event %0d click %0b pressed %0b dur %0d",
						want.event_code, want.click, want.is_pressed, want.pressed_duration);
					$display("          got event %0d click %0b pressed %0b dur %0d",
						got.event_code, got.click, got.is_pressed, got.pressed_duration);
				end
			end
		endfunction

		function int pending();
			return expected_events.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_index_t cfg_index;
	cfg_data_t cfg_wdata;

	bdhe_in_if sample_if ();
	bdhe_out_if result_if ();

	button_debounce_hold_events dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample(sample_if),
		.result(result_if)
	);

	event_scoreboard events_sb = new();

	// Idle percentages of the two sides, changed between phases by the stimulus process.
	int send_idle_pct;
	int recv_idle_pct;
	// The stimulus bumps this to ask the receiver for one long hold-off.
	int hold_off_req;
	longint unsigned cycle_count = 0;

	// Register values as the block holds them, used only to shape the traffic.
	int cur_debounce;
	longint unsigned cur_first;
	longint unsigned cur_next;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a correct run ends long before this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Monitor: both handshakes are sampled on the rising edge, where every input driven at
	// the falling edge has settled and the block's registers still show their old values.
	always @(posedge clk) begin
		result_t got;

		if (arst_n && sample_if.valid && sample_if.ready)
			events_sb.note_sample(sample_if.pin_level);
		if (arst_n && result_if.valid && result_if.ready) begin
			got.event_code = event_t'(result_if.event_code);
			got.click = result_if.click;
			got.is_pressed = result_if.is_pressed;
			got.pressed_duration = result_if.pressed_duration;
			events_sb.check_result(got);
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request. The hold-off is counted
	// here so the stimulus can carry on offering samples while the output side is blocked.
	initial begin
		int hold_off_seen;
		int hold_off_left;

		hold_off_seen = 0;
		hold_off_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_seen != hold_off_req) begin
				hold_off_seen = hold_off_req;
				hold_off_left = HOLD_OFF_CYCLES;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offers one sample and returns on the falling edge after its transaction. The caller
	// is always at a falling edge, so each step carries at most one assignment to valid.
	task automatic send_sample(input logic pin);
		logic taken;

		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_if.valid <= 1'b0;
			@(negedge clk);
		end
		sample_if.valid <= 1'b1;
		sample_if.pin_level <= pin;
		do begin
			@(posedge clk);
			taken = sample_if.ready;
			@(negedge clk);
		end while (!taken);
	endtask

	// Stops offering and waits until every queued result has been taken.
	task automatic settle_block();
		sample_if.valid <= 1'b0;
		while (events_sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input cfg_data_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		events_sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Writes all three registers; only the low 16 bits of the debounce word take effect.
	task automatic set_registers(input cfg_data_t deb_word, input cfg_data_t first_word,
			input cfg_data_t next_word);
		write_register(CFG_DEBOUNCE_TICKS, deb_word);
		write_register(CFG_FIRST_HOLD_TICKS, first_word);
		write_register(CFG_NEXT_HOLD_TICKS, next_word);
		cur_debounce = int'(deb_word[QUIET_WIDTH-1:0]);
		cur_first = 64'(first_word);
		cur_next = 64'(next_word);
	endtask

	// Mostly well-formed button activity: a short bounce burst followed by a steady run of
	// the opposite level, long enough in most cases to be accepted, and for presses long
	// enough to reach a hold or two when the thresholds are small. The rest is plain noise.
	// At hold_at the receiver is told to hold off; at pause_at the sender waits for the
	// block to drain completely.
	task automatic run_shaped_traffic(input int item_goal, input int hold_at,
			input int pause_at);
		int sent;
		int deb_part;
		int hold_part;
		int run_len;
		logic level;

		sent = 0;
		level = 1'b1;
		while (sent < item_goal) begin
			if (hold_at >= 0 && sent >= hold_at) begin
				hold_off_req++;
				hold_at = -1;
			end
			if (pause_at >= 0 && sent >= pause_at) begin
				settle_block();
				pause_at = -1;
			end
			if ($urandom_range(0, 99) < 80) begin
				repeat ($urandom_range(0, 4)) begin
					send_sample(1'($urandom_range(0, 1)));
					sent++;
				end
				level = ~level;
				deb_part = (cur_debounce > 12) ? 12 : cur_debounce;
				if (level == 1'b0)
					hold_part = ((cur_first > 30) ? 30 : int'(cur_first)) +
						3 * ((cur_next > 10) ? 10 : int'(cur_next)) + 4;
				else
					hold_part = 3;
				run_len = $urandom_range(deb_part / 2, deb_part + 1 + hold_part);
				repeat (run_len) begin
					send_sample(level);
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					send_sample(1'($urandom_range(0, 1)));
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEBOUNCE_TICKS;
		cfg_wdata = '0;
		sample_if.valid = 1'b0;
		sample_if.pin_level = 1'b1;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req = 0;
		cur_debounce = int'(RST_DEBOUNCE_TICKS);
		cur_first = 64'(RST_FIRST_HOLD_TICKS);
		cur_next = 64'(RST_NEXT_HOLD_TICKS);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. At the reset defaults a short bounce is simply filtered out.
		send_sample(1'b0);
		send_sample(1'b1);
		send_sample(1'b0);
		send_sample(1'b1);
		settle_block();

		// Debounce of zero written with junk in the upper bits, zero hold thresholds, and a
		// write past the register list that must be ignored.
		set_registers(32'hFFFF_0000, 32'd0, 32'd0);
		write_register(CFG_UNUSED, 32'h0001_2345);
		// The change tick never accepts, even with no debounce; then press, holds on every
		// tick, and a release after a hold gives no click.
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b1);
		send_sample(1'b1);
		// With zero thresholds even a short press holds before its release, so it gives no click.
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b1);
		send_sample(1'b1);
		settle_block();

		// The first hold uses its own threshold; an all-ones repeat threshold never fires.
		set_registers(32'd0, 32'd2, 32'hFFFF_FFFF);
		repeat (8) send_sample(1'b0);
		send_sample(1'b1);
		send_sample(1'b1);
		settle_block();

		// Random phases: sender idles lightly and receiver heavily, then the reverse, then
		// neither. Several register settings are visited, the extremes among them.
		send_idle_pct = 23;
		recv_idle_pct = 71;
		set_registers(32'd3, 32'd6, 32'd2);
		run_shaped_traffic(80, 40, -1);
		settle_block();
		set_registers({16'($urandom_range(0, 65535)), 16'd0}, 32'd0, 32'hFFFF_FFFF);
		run_shaped_traffic(80, -1, -1);
		settle_block();

		send_idle_pct = 71;
		recv_idle_pct = 23;
		set_registers(32'd1, 32'hFFFF_FFFF, 32'd0);
		run_shaped_traffic(80, -1, 40);
		settle_block();
		// Full-width random thresholds: holds are unlikely, but every hold register bit moves.
		set_registers({16'($urandom_range(0, 65535)), 16'd2}, $urandom, $urandom);
		run_shaped_traffic(80, -1, -1);
		settle_block();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_registers(32'd4, 32'd10, 32'd3);
		run_shaped_traffic(80, 30, -1);
		settle_block();
		set_registers(32'd0, 32'd1, 32'd1);
		run_shaped_traffic(80, -1, -1);
		settle_block();

		// A longer debounce: the press is only accepted after thirty steady ticks, and the
		// release needs the same again.
		set_registers(32'd30, 32'hFFFF_FFFF, 32'd0);
		send_sample(1'b1);
		repeat (36) send_sample(1'b0);
		repeat (36) send_sample(1'b1);
		settle_block();

		repeat (8) @(negedge clk);
		if (events_sb.mismatches == 0 && events_sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### button_debounce_hold_events.f
+incdir+hw/rtl
hw/rtl/bdhe_pkg.sv
hw/rtl/bdhe_in_if.sv
hw/rtl/bdhe_out_if.sv
hw/rtl/bdhe_debounce.sv
hw/rtl/bdhe_events.sv
hw/rtl/button_debounce_hold_events.sv
tb/tb.sv
